>>> src/dssp_pkg.sv
// ----------------------------------------------------------------------------
// Dual stepper package
// Command codes, shared widths and the control and status structures that
// pass between the top level and the per-motor slices.
// ----------------------------------------------------------------------------
package dssp_pkg;

  // Default width of the signed remaining-step counters.
  localparam int unsigned CountWidthDef = 24;
  // Width of the step count as shown on the result word.
  localparam int unsigned OutCountW     = 24;
  // Width of the signed step delta carried by an add-steps command.
  localparam int unsigned DeltaW        = 16;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_ENABLE = 3'd1,
    CMD_RUN    = 3'd2,
    CMD_DIR    = 3'd3,
    CMD_ADD    = 3'd4,
    CMD_SPEED  = 3'd5
  } cmd_e;

  // Control handed to one motor slice for the word being retired this cycle.
  typedef struct packed {
    logic                     tick;       // tick command retiring
    logic                     set_dir;    // set direction, this motor selected
    logic                     add_steps;  // add steps, this motor selected
    logic                     set_speed;  // set speed, this motor selected
    logic                     powered;    // driver power as held before the word
    logic                     running;    // run flag as held before the word
    logic                     backwards;
    logic [1:0]               speed;
    logic signed [DeltaW-1:0] delta;
  } motor_ctrl_t;

  // Motor state after the word, plus the direction clash flag.
  typedef struct packed {
    logic       phase;
    logic       dir;
    logic [1:0] code;
    logic       dir_refused;
  } motor_stat_t;

  // Steps taken off the count for each completed pulse.
  function automatic logic [3:0] step_weight(input logic [1:0] code);
    return 4'd8 >> code;
  endfunction

endpackage

>>> src/dssp_if.sv
// ----------------------------------------------------------------------------
// Dual stepper channel interfaces
// Command channel and result channel, each with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface dssp_in_if;
  logic                              valid;
  logic                              ready;
  logic [2:0]                        command;
  logic                              side;
  logic                              on_off;
  logic                              backwards;
  logic [1:0]                        speed_code;
  logic signed [dssp_pkg::DeltaW-1:0] step_delta;

  modport source (output valid, command, side, on_off, backwards, speed_code, step_delta,
                  input ready);
  modport sink   (input valid, command, side, on_off, backwards, speed_code, step_delta,
                  output ready);
endinterface

interface dssp_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 accepted;
  logic                                 step_pin_left;
  logic                                 step_pin_right;
  logic                                 enable_pin;
  logic                                 dir_pin_left;
  logic                                 dir_pin_right;
  logic [1:0]                           mode_pins_left;
  logic [1:0]                           mode_pins_right;
  logic                                 running_now;
  logic signed [dssp_pkg::OutCountW-1:0] remaining_left;
  logic signed [dssp_pkg::OutCountW-1:0] remaining_right;

  modport source (output valid, accepted, step_pin_left, step_pin_right, enable_pin,
                  dir_pin_left, dir_pin_right, mode_pins_left, mode_pins_right,
                  running_now, remaining_left, remaining_right,
                  input ready);
  modport sink   (input valid, accepted, step_pin_left, step_pin_right, enable_pin,
                  dir_pin_left, dir_pin_right, mode_pins_left, mode_pins_right,
                  running_now, remaining_left, remaining_right,
                  output ready);
endinterface

>>> src/dssp_motor.sv
// ----------------------------------------------------------------------------
// Dual stepper motor slice
// Direction, microstep code, pulse phase and saturating step counter of one
// motor, with their next values shown for the result register.
// ----------------------------------------------------------------------------
module dssp_motor #(
  parameter int unsigned CountWidth = dssp_pkg::CountWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  dssp_pkg::motor_ctrl_t         ctrl_i,
  output dssp_pkg::motor_stat_t         stat_o,
  output logic signed [dssp_pkg::OutCountW-1:0] remaining_o
);

  localparam int unsigned ExtW = CountWidth + dssp_pkg::OutCountW;

  logic                         dir_q, dir_d;
  logic [1:0]                   code_q, code_d;
  logic                         phase_q, phase_d;
  logic signed [CountWidth-1:0] count_q, count_d;

  logic                         active;
  logic                         clash;
  logic signed [CountWidth:0]   sum;
  logic signed [ExtW-1:0]       count_ext;

  assign active = ctrl_i.powered && ctrl_i.running && (count_q > 0);
  assign clash  = (ctrl_i.backwards != dir_q) && ctrl_i.running;
  assign sum    = (CountWidth+1)'(count_q) + (CountWidth+1)'(ctrl_i.delta);

  always_comb begin
    dir_d   = dir_q;
    code_d  = code_q;
    phase_d = phase_q;
    count_d = count_q;
    if (ctrl_i.tick) begin
      if (active) begin
        phase_d = ~phase_q;
        // A pulse completes on its falling edge.
        if (phase_q) begin
          count_d = count_q - CountWidth'(dssp_pkg::step_weight(code_q));
        end
      end else begin
        phase_d = 1'b0;
        if (count_q < 0) begin
          count_d = '0;
        end
      end
    end
    if (ctrl_i.set_dir && !clash) begin
      dir_d = ctrl_i.backwards;
    end
    if (ctrl_i.set_speed) begin
      code_d = ctrl_i.speed;
    end
    if (ctrl_i.add_steps) begin
      if (sum[CountWidth] != sum[CountWidth-1]) begin
        // Overflow: clamp to the end of the range that the sign points to.
        count_d = sum[CountWidth] ? {1'b1, {(CountWidth-1){1'b0}}}
                                  : {1'b0, {(CountWidth-1){1'b1}}};
      end else begin
        count_d = sum[CountWidth-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= 1'b0;
      code_q  <= 2'd3;
      phase_q <= 1'b0;
      count_q <= '0;
    end else if (fire_i) begin
      dir_q   <= dir_d;
      code_q  <= code_d;
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  assign count_ext   = ExtW'(count_d);
  assign remaining_o = count_ext[dssp_pkg::OutCountW-1:0];

  assign stat_o.phase       = phase_d;
  assign stat_o.dir         = dir_d;
  assign stat_o.code        = code_d;
  assign stat_o.dir_refused = ctrl_i.set_dir && clash;

endmodule

>>> src/dual_stepper_step_pulse_generator.sv
// ----------------------------------------------------------------------------
// Dual stepper step pulse generator
// A command word taken into the command register moves on to the result register
// once that register is empty or being read, and its result word is then offered.
// Throughput: one command word per cycle unless the result channel stalls.
// Each word gives exactly one result word showing the state after that command.
// Reset (asynchronous, active low) powers down, stops, sets both motors forwards
// at eighth step with the pulse low and a zero count, and empties both stages.
// ----------------------------------------------------------------------------
module dual_stepper_step_pulse_generator #(
  parameter int unsigned COUNT_WIDTH = dssp_pkg::CountWidthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dssp_in_if.sink    in_i,
  dssp_out_if.source out_o
);

  // The design is two registers deep. The command register holds one accepted
  // word; once the result register is empty or being read, the word passes
  // through the command decode and the two motor slices into the result
  // register, while the motor and global state take their new values at the same
  // edge. So the next word, taken in that same cycle, sees the updated state.

  // Command register.
  logic                                 cmd_vld_q;
  dssp_pkg::cmd_e                       cmd_q;
  logic                                 side_q;
  logic                                 on_q;
  logic                                 back_q;
  logic [1:0]                           speed_q;
  logic signed [dssp_pkg::DeltaW-1:0]   delta_q;

  // Global state shared by both motors.
  logic powered_q, powered_d;
  logic run_q, run_d;

  // Result register.
  logic                                 res_vld_q;
  logic                                 acc_q;
  logic                                 pow_res_q;
  logic                                 run_res_q;
  dssp_pkg::motor_stat_t                stat_l_q, stat_r_q;
  logic signed [dssp_pkg::OutCountW-1:0] rem_l_q, rem_r_q;

  logic                                 advance;
  logic                                 fire;
  logic                                 run_refused;
  logic                                 accepted_d;
  dssp_pkg::motor_ctrl_t                ctrl_l, ctrl_r;
  dssp_pkg::motor_stat_t                stat_l, stat_r;
  logic signed [dssp_pkg::OutCountW-1:0] rem_l, rem_r;

  // The result register moves on whenever it is empty or being read, and the
  // command register can refill in the same cycle its word moves on. A word
  // is therefore still taken while one finished result waits downstream,
  // provided the command register is empty.
  assign advance    = !res_vld_q || out_o.ready;
  assign fire       = cmd_vld_q && advance;
  assign in_i.ready = !cmd_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      cmd_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q   <= dssp_pkg::cmd_e'(in_i.command);
      side_q  <= in_i.side;
      on_q    <= in_i.on_off;
      back_q  <= in_i.backwards;
      speed_q <= in_i.speed_code;
      delta_q <= in_i.step_delta;
    end
  end

  // Power and run flags. Switching power off also stops the motors, and a
  // run request is refused while the drivers are unpowered.
  always_comb begin
    powered_d   = powered_q;
    run_d       = run_q;
    run_refused = 1'b0;
    case (cmd_q)
      dssp_pkg::CMD_ENABLE: begin
        powered_d = on_q;
        if (!on_q) begin
          run_d = 1'b0;
        end
      end
      dssp_pkg::CMD_RUN: begin
        if (on_q && !powered_q) begin
          run_refused = 1'b1;
        end else begin
          run_d = on_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Per-motor control: the tick and the power and run flags reach both
  // motors, the other commands only the one that the side bit selects.
  always_comb begin
    ctrl_l.tick      = (cmd_q == dssp_pkg::CMD_TICK);
    ctrl_l.set_dir   = (cmd_q == dssp_pkg::CMD_DIR)   && !side_q;
    ctrl_l.add_steps = (cmd_q == dssp_pkg::CMD_ADD)   && !side_q;
    ctrl_l.set_speed = (cmd_q == dssp_pkg::CMD_SPEED) && !side_q;
    ctrl_l.powered   = powered_q;
    ctrl_l.running   = run_q;
    ctrl_l.backwards = back_q;
    ctrl_l.speed     = speed_q;
    ctrl_l.delta     = delta_q;

    ctrl_r           = ctrl_l;
    ctrl_r.set_dir   = (cmd_q == dssp_pkg::CMD_DIR)   && side_q;
    ctrl_r.add_steps = (cmd_q == dssp_pkg::CMD_ADD)   && side_q;
    ctrl_r.set_speed = (cmd_q == dssp_pkg::CMD_SPEED) && side_q;
  end

  dssp_motor #(
    .CountWidth (COUNT_WIDTH)
  ) u_motor_l (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .ctrl_i      (ctrl_l),
    .stat_o      (stat_l),
    .remaining_o (rem_l)
  );

  dssp_motor #(
    .CountWidth (COUNT_WIDTH)
  ) u_motor_r (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .ctrl_i      (ctrl_r),
    .stat_o      (stat_r),
    .remaining_o (rem_r)
  );

  assign accepted_d = !(run_refused || stat_l.dir_refused || stat_r.dir_refused);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      powered_q <= 1'b0;
      run_q     <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (fire) begin
        powered_q <= powered_d;
        run_q     <= run_d;
      end
      if (advance) begin
        res_vld_q <= cmd_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      acc_q     <= accepted_d;
      pow_res_q <= powered_d;
      run_res_q <= run_d;
      stat_l_q  <= stat_l;
      stat_r_q  <= stat_r;
      rem_l_q   <= rem_l;
      rem_r_q   <= rem_r;
    end
  end

  // The left direction pin is high for forwards, the right one low, as the
  // two motors are mounted facing opposite ways.
  assign out_o.valid           = res_vld_q;
  assign out_o.accepted        = acc_q;
  assign out_o.step_pin_left   = stat_l_q.phase;
  assign out_o.step_pin_right  = stat_r_q.phase;
  assign out_o.enable_pin      = pow_res_q;
  assign out_o.dir_pin_left    = ~stat_l_q.dir;
  assign out_o.dir_pin_right   = stat_r_q.dir;
  assign out_o.mode_pins_left  = stat_l_q.code;
  assign out_o.mode_pins_right = stat_r_q.code;
  assign out_o.running_now     = run_res_q;
  assign out_o.remaining_left  = rem_l_q;
  assign out_o.remaining_right = rem_r_q;

endmodule

>>> src/dssp_checker.sv
// ----------------------------------------------------------------------------
// Dual stepper port checker
// Checks on the handshake and on the result words seen at the top level ports.
// ----------------------------------------------------------------------------
module dssp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic accepted_i,
  input logic enable_pin_i,
  input logic running_now_i
);

  // A result word stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped before it was taken");

  // Commands are only held off while a finished result is waiting.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("command channel stalled with no result backing up");

  // The motors can only be running while the drivers are powered.
  a_run_powered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && running_now_i |-> enable_pin_i)
    else $error("run flag set while drivers are unpowered");

  // A refused command is either a run request while unpowered or a direction
  // change while running.
  a_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !accepted_i |-> !enable_pin_i || running_now_i)
    else $error("command refused for no reason");

endmodule

bind dual_stepper_step_pulse_generator dssp_checker u_dssp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .accepted_i    (out_o.accepted),
  .enable_pin_i  (out_o.enable_pin),
  .running_now_i (out_o.running_now)
);

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// Dual stepper step pulse generator testbench
// Drives command words into the block through the valid/ready channel, and
// predicts each status word with an independent model of both motors. Every
// status word that comes back is compared field by field with the oldest
// prediction. A short directed sequence is followed by randomised motor
// sessions, two saturation bursts and general noise. Both sides of the
// handshake stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import dssp_pkg::*;

  // The block is built with its default counter width, which matches the
  // width of the remaining-step fields on the status word.
  localparam int unsigned CountW     = CountWidthDef;
  localparam longint      CountMax   = (longint'(1) <<< (CountW - 1)) - 1;
  localparam longint      CountMin   = -CountMax - 1;
  localparam int          CycleLimit = 100000;

  // Command codes that the package leaves unnamed; the block must treat them
  // as no-ops that are always accepted.
  localparam logic [2:0] CmdSpare6 = 3'd6;
  localparam logic [2:0] CmdSpare7 = 3'd7;

  typedef struct packed {
    logic [2:0]               command;
    logic                     side;
    logic                     on_off;
    logic                     backwards;
    logic [1:0]               speed_code;
    logic signed [DeltaW-1:0] step_delta;
  } cmd_word_t;

  typedef struct packed {
    logic                        accepted;
    logic                        step_pin_left;
    logic                        step_pin_right;
    logic                        enable_pin;
    logic                        dir_pin_left;
    logic                        dir_pin_right;
    logic [1:0]                  mode_pins_left;
    logic [1:0]                  mode_pins_right;
    logic                        running_now;
    logic signed [OutCountW-1:0] remaining_left;
    logic signed [OutCountW-1:0] remaining_right;
  } status_word_t;

  bit   clk_i = 1'b0;
  logic rst_n = 1'b0;

  dssp_in_if  cmd_if ();
  dssp_out_if sts_if ();

  dual_stepper_step_pulse_generator #(
    .COUNT_WIDTH(CountW)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_n),
    .in_i  (cmd_if),
    .out_o (sts_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Words waiting to be driven, and status words predicted but not yet seen.
  cmd_word_t    cmd_backlog[$];
  status_word_t status_due[$];

  int   fault_cnt = 0;
  int   cyc       = 0;
  logic word_taken;

  // For a stretch of the run neither side stalls, so that the block is also
  // exercised at its full rate of one word per cycle.
  wire calm = (cyc >= 300) && (cyc < 900);

  // --------------------------------------------------------------------------
  // Motor model. This holds its own copy of the shared power and run flags
  // and of each motor's direction, microstep code, pulse phase and count.
  // --------------------------------------------------------------------------
  logic                     pwr_m;
  logic                     run_m;
  logic                     dir_m   [2];
  logic [1:0]               code_m  [2];
  logic                     phase_m [2];
  logic signed [CountW-1:0] count_m [2];

  function automatic void clear_motors();
    pwr_m = 1'b0;
    run_m = 1'b0;
    for (int m = 0; m < 2; m++) begin
      dir_m[m]   = 1'b0;
      code_m[m]  = 2'd3;
      phase_m[m] = 1'b0;
      count_m[m] = '0;
    end
  endfunction

  // One tick on one motor. A motor that may step toggles its pin, and on the
  // falling half of the pulse takes 8 >> code off its count. Any motor that
  // cannot step holds its pin low and has a negative count cleared.
  function automatic void pulse_motor(input int m);
    if (pwr_m && run_m && count_m[m] > 0) begin
      if (!phase_m[m]) begin
        phase_m[m] = 1'b1;
      end else begin
        phase_m[m] = 1'b0;
        count_m[m] = CountW'(longint'(count_m[m]) - (longint'(8) >> code_m[m]));
      end
    end else begin
      phase_m[m] = 1'b0;
      if (count_m[m] < 0) begin
        count_m[m] = '0;
      end
    end
  endfunction

  // Applies one command word to the model and returns the status after it.
  function automatic status_word_t next_status(input cmd_word_t w);
    status_word_t st;
    logic         ok;
    longint       sum;
    ok = 1'b1;
    case (w.command)
      CMD_TICK: begin
        pulse_motor(0);
        pulse_motor(1);
      end
      CMD_ENABLE: begin
        // Powering down also stops the motors.
        pwr_m = w.on_off;
        if (!w.on_off) begin
          run_m = 1'b0;
        end
      end
      CMD_RUN: begin
        // Running is refused while the drivers are unpowered.
        if (!w.on_off) begin
          run_m = 1'b0;
        end else if (pwr_m) begin
          run_m = 1'b1;
        end else begin
          ok = 1'b0;
        end
      end
      CMD_DIR: begin
        // Reversing is refused while running; restating the direction is not.
        if (w.backwards != dir_m[w.side] && run_m) begin
          ok = 1'b0;
        end else begin
          dir_m[w.side] = w.backwards;
        end
      end
      CMD_ADD: begin
        sum = longint'(count_m[w.side]) + longint'($signed(w.step_delta));
        if (sum > CountMax) begin
          sum = CountMax;
        end
        if (sum < CountMin) begin
          sum = CountMin;
        end
        count_m[w.side] = CountW'(sum);
      end
      CMD_SPEED: begin
        code_m[w.side] = w.speed_code;
      end
      default: begin
      end
    endcase
    st.accepted        = ok;
    st.step_pin_left   = phase_m[0];
    st.step_pin_right  = phase_m[1];
    st.enable_pin      = pwr_m;
    st.dir_pin_left    = ~dir_m[0];
    st.dir_pin_right   = dir_m[1];
    st.mode_pins_left  = code_m[0];
    st.mode_pins_right = code_m[1];
    st.running_now     = run_m;
    st.remaining_left  = OutCountW'(count_m[0]);
    st.remaining_right = OutCountW'(count_m[1]);
    return st;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic push_op(input logic [2:0] op, input logic s, input logic on,
                         input logic b, input logic [1:0] sp, input int d);
    cmd_word_t w;
    w.command    = op;
    w.side       = s;
    w.on_off     = on;
    w.backwards  = b;
    w.speed_code = sp;
    w.step_delta = DeltaW'(d);
    cmd_backlog.push_back(w);
  endtask

  // A word of any kind, weighted towards ticks. Fields that the command does
  // not use are random as well, so that every input bit is toggled.
  function automatic cmd_word_t any_word();
    cmd_word_t   w;
    int unsigned pick;
    pick         = $urandom_range(99);
    w.side       = $urandom_range(1);
    w.on_off     = ($urandom_range(99) < 75);
    w.backwards  = $urandom_range(1);
    w.speed_code = $urandom_range(3);
    if ($urandom_range(3) == 0) begin
      w.step_delta = DeltaW'($urandom);
    end else begin
      w.step_delta = DeltaW'(int'($urandom_range(80)) - 20);
    end
    if (pick < 40) begin
      w.command = CMD_TICK;
    end else if (pick < 48) begin
      w.command = CMD_ENABLE;
    end else if (pick < 58) begin
      w.command = CMD_RUN;
    end else if (pick < 70) begin
      w.command = CMD_DIR;
    end else if (pick < 82) begin
      w.command = CMD_ADD;
    end else if (pick < 92) begin
      w.command = CMD_SPEED;
    end else begin
      w.command = $urandom_range(1) ? CmdSpare6 : CmdSpare7;
    end
    return w;
  endfunction

  // A random word turned into the given command with the switch set on and,
  // for adds, a small positive delta, so that a session actually runs.
  task automatic push_session_op(input logic [2:0] op);
    cmd_word_t w;
    w         = any_word();
    w.command = op;
    w.on_off  = 1'b1;
    if (op == CMD_ADD) begin
      w.step_delta = DeltaW'($urandom_range(60, 1));
    end
    cmd_backlog.push_back(w);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fault_cnt++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver. Inputs change on the falling edge. A new word is put on the bus
  // only when the bus is idle or the previous one was taken at the last rising
  // edge, and the valid line is written at most once per edge.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    cmd_word_t w;
    if (rst_n && (!cmd_if.valid || word_taken)) begin
      if (cmd_backlog.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
        w = cmd_backlog.pop_front();
        cmd_if.valid      <= 1'b1;
        cmd_if.command    <= w.command;
        cmd_if.side       <= w.side;
        cmd_if.on_off     <= w.on_off;
        cmd_if.backwards  <= w.backwards;
        cmd_if.speed_code <= w.speed_code;
        cmd_if.step_delta <= w.step_delta;
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
    sts_if.ready <= rst_n && (calm || $urandom_range(99) >= 20);
  end

  // --------------------------------------------------------------------------
  // Monitor. At each rising edge the status word taken, if any, is checked
  // against the oldest prediction, and then the command word taken, if any,
  // is run through the model. As a word passes the command register first,
  // its prediction is always queued before its status word arrives.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    status_word_t due;
    cmd_word_t    w;
    cyc++;
    if (cyc >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end else if (!rst_n) begin
      clear_motors();
      word_taken <= 1'b0;
    end else begin
      if (sts_if.valid && sts_if.ready) begin
        if (status_due.size() == 0) begin
          $error("status word arrived with no prediction waiting");
          fault_cnt++;
        end else begin
          due = status_due.pop_front();
          check_field("accepted", due.accepted, sts_if.accepted);
          check_field("step_pin_left", due.step_pin_left, sts_if.step_pin_left);
          check_field("step_pin_right", due.step_pin_right, sts_if.step_pin_right);
          check_field("enable_pin", due.enable_pin, sts_if.enable_pin);
          check_field("dir_pin_left", due.dir_pin_left, sts_if.dir_pin_left);
          check_field("dir_pin_right", due.dir_pin_right, sts_if.dir_pin_right);
          check_field("mode_pins_left", due.mode_pins_left, sts_if.mode_pins_left);
          check_field("mode_pins_right", due.mode_pins_right, sts_if.mode_pins_right);
          check_field("running_now", due.running_now, sts_if.running_now);
          check_field("remaining_left", due.remaining_left, sts_if.remaining_left);
          check_field("remaining_right", due.remaining_right, sts_if.remaining_right);
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        w = '{command:    cmd_if.command,
              side:       cmd_if.side,
              on_off:     cmd_if.on_off,
              backwards:  cmd_if.backwards,
              speed_code: cmd_if.speed_code,
              step_delta: cmd_if.step_delta};
        status_due.push_back(next_status(w));
      end
      word_taken <= cmd_if.valid && cmd_if.ready;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin
    int s;
    cmd_if.valid      = 1'b0;
    cmd_if.command    = CMD_TICK;
    cmd_if.side       = 1'b0;
    cmd_if.on_off     = 1'b0;
    cmd_if.backwards  = 1'b0;
    cmd_if.speed_code = 2'd0;
    cmd_if.step_delta = '0;
    sts_if.ready      = 1'b0;

    // Directed part. It starts from the reset state, tries the unused codes,
    // a run while unpowered, the extreme deltas, a negative count being
    // cleared by a tick, a reversal while running, a speed change in the
    // middle of a pulse, and powering down while running.
    push_op(CMD_TICK,   1'b0, 1'b0, 1'b0, 2'd0, 0);
    push_op(CmdSpare6,  1'b1, 1'b1, 1'b1, 2'd3, -1);
    push_op(CmdSpare7,  1'b0, 1'b1, 1'b0, 2'd1, 1);
    push_op(CMD_RUN,    1'b0, 1'b1, 1'b0, 2'd0, 0);
    push_op(CMD_ADD,    1'b0, 1'b0, 1'b0, 2'd0, 32767);
    push_op(CMD_ADD,    1'b1, 1'b0, 1'b0, 2'd0, -32768);
    push_op(CMD_TICK,   1'b0, 1'b0, 1'b0, 2'd0, 0);
    push_op(CMD_ENABLE, 1'b0, 1'b1, 1'b0, 2'd0, 0);
    push_op(CMD_SPEED,  1'b0, 1'b0, 1'b0, 2'd0, 0);
    push_op(CMD_SPEED,  1'b1, 1'b0, 1'b0, 2'd2, 0);
    push_op(CMD_RUN,    1'b0, 1'b1, 1'b0, 2'd0, 0);
    push_op(CMD_DIR,    1'b0, 1'b0, 1'b1, 2'd0, 0);
    push_op(CMD_DIR,    1'b1, 1'b0, 1'b0, 2'd0, 0);
    push_op(CMD_ADD,    1'b1, 1'b0, 1'b0, 2'd0, 5);
    push_op(CMD_TICK,   1'b0, 1'b0, 1'b0, 2'd0, 0);
    push_op(CMD_TICK,   1'b0, 1'b0, 1'b0, 2'd0, 0);
    push_op(CMD_TICK,   1'b0, 1'b0, 1'b0, 2'd0, 0);
    push_op(CMD_SPEED,  1'b1, 1'b0, 1'b0, 2'd1, 0);
    push_op(CMD_TICK,   1'b0, 1'b0, 1'b0, 2'd0, 0);
    push_op(CMD_TICK,   1'b0, 1'b0, 1'b0, 2'd0, 0);
    push_op(CMD_RUN,    1'b0, 1'b0, 1'b0, 2'd0, 0);
    push_op(CMD_DIR,    1'b0, 1'b0, 1'b1, 2'd0, 0);
    push_op(CMD_RUN,    1'b1, 1'b1, 1'b0, 2'd0, 0);
    push_op(CMD_ENABLE, 1'b0, 1'b0, 1'b0, 2'd0, 0);
    push_op(CMD_SPEED,  1'b0, 1'b0, 1'b0, 2'd3, 0);

    // Motor sessions: power up, set speed twice and a direction, add steps
    // twice on random motors, run, then mostly ticks with some noise mixed in.
    for (int k = 0; k < 2; k++) begin
      push_session_op(CMD_ENABLE);
      push_session_op(CMD_SPEED);
      push_session_op(CMD_SPEED);
      push_session_op(CMD_DIR);
      push_session_op(CMD_ADD);
      push_session_op(CMD_ADD);
      push_session_op(CMD_RUN);
      repeat ($urandom_range(40, 15)) begin
        if ($urandom_range(4) == 0) begin
          cmd_backlog.push_back(any_word());
        end else begin
          push_session_op(CMD_TICK);
        end
      end
      if ($urandom_range(1)) begin
        push_op(CMD_RUN, $urandom_range(1), 1'b0, $urandom_range(1), $urandom_range(3), 0);
      end
    end

    // Saturation: drive one count into its upper limit and the other into
    // its lower limit, with ticks in between.
    s = $urandom_range(1);
    repeat (262) begin
      push_op(CMD_ADD, s[0], 1'b0, 1'b0, 2'd0, $urandom_range(32767, 32700));
    end
    repeat (4) begin
      push_op(CMD_TICK, 1'b0, 1'b0, 1'b0, 2'd0, 0);
    end
    repeat (262) begin
      push_op(CMD_ADD, !s[0], 1'b0, 1'b0, 2'd0, -32768);
    end
    push_op(CMD_TICK, 1'b0, 1'b0, 1'b0, 2'd0, 0);

    // General noise.
    repeat (10) begin
      cmd_backlog.push_back(any_word());
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    // Wait until every word has been driven and every status word seen.
    do begin
      @(negedge clk_i);
    end while (cmd_backlog.size() != 0 || cmd_if.valid || status_due.size() != 0);

    // Then wait on to catch any stray status word.
    repeat (10) @(negedge clk_i);
    if (fault_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/dssp_pkg.sv
src/dssp_if.sv
src/dssp_motor.sv
src/dual_stepper_step_pulse_generator.sv
src/dssp_checker.sv
verif/tb_top.sv
